/* rtl/kppr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kppr_pkg
// Shared types, constants and the byte classifier for the keystroke program
// pack and relink unit.
// ----------------------------------------------------------------------------
package kppr_pkg;

  localparam int unsigned ADDR_W = 20;
  localparam int unsigned BYTE_W = 8;

  localparam logic [ADDR_W-1:0] ADDR_STEP = 20'd2;
  localparam logic [ADDR_W-1:0] LINK_BIAS = 20'd4;

  // d / 7 == (d * DIV7_RECIP) >> DIV7_SHIFT for every 19-bit d
  localparam logic [19:0]  DIV7_RECIP = 20'd599187;
  localparam int unsigned  DIV7_SHIFT = 22;

  localparam logic [BYTE_W-1:0] END_CODE   = 8'h09;
  localparam logic [BYTE_W-1:0] GLOBAL_TAG = 8'hC0;
  localparam logic [BYTE_W-1:0] NUM_LO     = 8'h10;
  localparam logic [BYTE_W-1:0] NUM_HI     = 8'h1C;
  localparam logic [BYTE_W-1:0] TRI1_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] TRI3_MASK  = 8'h7F;
  localparam logic [BYTE_W-1:0] TEXT_LO    = 8'hF0;

  typedef enum logic [3:0] {
    K_FIRST, K_SINGLE, K_DBL1, K_DBL2, K_TRI1, K_TRI2, K_TRI3, K_TEXT,
    K_JTEXT, K_GLB1, K_GLB2, K_GLBL, K_GEND, K_GKEY, K_LOC1, K_LOC2
  } kppr_kind_e;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_PRIOR = 2'd2
  } kppr_reg_e;

  // one classified beat handed from the front end to the back end
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              glb1;
    logic              glb2;
    logic              zero;
    logic              keep;
    logic              fin;
  } kppr_item_t;

  function automatic kppr_kind_e fresh_kind(input logic [BYTE_W-1:0] b);
    kppr_kind_e k;
    if ((b >= 8'h90 && b <= 8'hB0) || b == 8'hCE || b == 8'hCF) begin
      k = K_DBL1;
    end else if (b >= 8'hB1 && b <= 8'hBF) begin
      k = K_LOC1;
    end else if (b >= 8'hD0 && b <= 8'hEF) begin
      k = K_TRI1;
    end else if (b >= TEXT_LO) begin
      k = K_TEXT;
    end else if (b >= 8'h1D && b <= 8'h1F) begin
      k = K_JTEXT;
    end else if (b >= 8'hC0 && b <= 8'hCD) begin
      k = K_GLB1;
    end else begin
      k = K_SINGLE;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

/* rtl/kppr_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kppr_front
// Instruction-length decoder: classifies each byte, keeps the text counter and
// number-run flag, and pushes a classified item into the queue.
// ----------------------------------------------------------------------------
module kppr_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire  [kppr_pkg::BYTE_W-1:0] code_byte_i,
  input  wire                       final_byte_i,
  input  wire                       q_ready_i,
  output logic                      push_o,
  output kppr_pkg::kppr_item_t      item_o
);
  import kppr_pkg::*;

  kppr_kind_e  prev_q;
  logic [3:0]  text_q, text_d;
  logic        in_num_q;
  kppr_kind_e  kind;
  logic        num;
  logic [BYTE_W-1:0] data;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  always_comb begin
    text_d = text_q;
    kind   = K_SINGLE;
    unique case (prev_q)
      K_LOC1: kind = K_LOC2;
      K_DBL1: kind = K_DBL2;
      K_TRI1: kind = K_TRI2;
      K_TRI2: kind = K_TRI3;
      K_GLB1: kind = K_GLB2;
      K_TEXT, K_GKEY: begin
        if (text_q != 4'd0) begin
          text_d = text_q - 4'd1;
          kind   = K_TEXT;
        end else begin
          kind = fresh_kind(code_byte_i);
        end
      end
      K_JTEXT: begin
        if (code_byte_i > TEXT_LO) begin
          kind = K_TEXT;
        end else begin
          kind = fresh_kind(code_byte_i);
        end
      end
      K_GLB2: begin
        if (code_byte_i >= TEXT_LO) begin
          text_d = code_byte_i[3:0];
          kind   = K_GLBL;
        end else begin
          kind = K_GEND;
        end
      end
      K_GLBL: begin
        if (text_q != 4'd0) begin
          text_d = text_q - 4'd1;
          kind   = K_GKEY;
        end else begin
          kind = fresh_kind(code_byte_i);
        end
      end
      default: kind = fresh_kind(code_byte_i);
    endcase
    // a fresh text prefix loads its length
    if (kind == K_TEXT && !(prev_q == K_TEXT || prev_q == K_GKEY) || (prev_q == K_JTEXT &&
        kind == K_TEXT)) begin
      if ((prev_q != K_TEXT && prev_q != K_GKEY) || text_q == 4'd0) begin
        text_d = code_byte_i[3:0];
      end
    end
    if ((prev_q == K_TEXT || prev_q == K_GKEY) && text_q == 4'd0 && kind == K_TEXT) begin
      text_d = code_byte_i[3:0];
    end
  end

  always_comb begin
    data = code_byte_i;
    unique case (kind)
      K_GEND:                 data = END_CODE;
      K_GKEY, K_LOC2, K_TRI2: data = '0;
      K_TRI1:                 data = code_byte_i & TRI1_MASK;
      K_TRI3:                 data = code_byte_i & TRI3_MASK;
      default:                data = code_byte_i;
    endcase
    num         = (kind == K_SINGLE) && code_byte_i >= NUM_LO && code_byte_i <= NUM_HI;
    item_o.data = data;
    item_o.glb1 = (kind == K_GLB1);
    item_o.glb2 = (kind == K_GLB2);
    item_o.zero = in_num_q && !num;
    item_o.keep = (kind != K_SINGLE) || (code_byte_i != '0);
    item_o.fin  = final_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= K_FIRST;
      text_q   <= 4'd0;
      in_num_q <= 1'b0;
    end else if (push_o) begin
      if (final_byte_i) begin
        prev_q   <= K_FIRST;
        text_q   <= 4'd0;
        in_num_q <= 1'b0;
      end else begin
        prev_q   <= kind;
        text_q   <= text_d;
        in_num_q <= num;
      end
    end
  end

`ifndef SYNTHESIS
  a_fin_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && item_o.fin) |=> (prev_q == K_FIRST && text_q == 4'd0 && !in_num_q))
    else $error("decoder not rearmed after final beat");
  a_glb2_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && item_o.glb1 && !item_o.fin) |=> (prev_q == K_GLB1))
    else $error("global header state lost");
  a_zero_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && item_o.zero) |-> in_num_q)
    else $error("end-of-number zero without number run");
`endif

endmodule
`default_nettype wire

/* rtl/kppr_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kppr_queue
// Two-entry queue of classified items between the decoder and the sequencer.
// ----------------------------------------------------------------------------
module kppr_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  kppr_pkg::kppr_item_t item_i,
  output logic                 ready_o,
  input  wire                  pop_i,
  output logic                 valid_o,
  output kppr_pkg::kppr_item_t item_o
);
  import kppr_pkg::*;

  kppr_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2 || pop_i))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

/* rtl/kppr_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kppr_back
// Sequencer: holds the address registers, computes link offsets with a
// reciprocal multiply, and writes out up to four result beats per item.
// ----------------------------------------------------------------------------
module kppr_back (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [1:0]                  cfg_index_i,
  input  wire  [kppr_pkg::ADDR_W-1:0] cfg_data_i,
  input  wire                         q_valid_i,
  input  kppr_pkg::kppr_item_t        q_item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [kppr_pkg::ADDR_W-1:0] write_address_o,
  output logic [kppr_pkg::BYTE_W-1:0] write_data_o,
  output logic                        run_last_o
);
  import kppr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_GDIV, S_ZERO, S_BYTE, S_EDIV, S_END1, S_END2
  } state_e;

  state_e            state_q;
  kppr_item_t        cur_q;
  logic [ADDR_W-1:0] start_q, end_q, prior_q, next_addr_q, last_glb_q;
  logic [BYTE_W-1:0] held_q;
  logic [8:0]        quo_q;
  logic [2:0]        dlo_q;
  logic              lz_q;
  logic              out_valid_q, run_last_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [BYTE_W-1:0] out_data_q;

  logic              emit_free;
  logic              emit_now;
  logic [ADDR_W-1:0] div_addr, diff;
  logic [18:0]       dval;
  logic [38:0]       prod;
  logic [2:0]        rem;
  logic [3:0]        byt;
  logic [BYTE_W-1:0] regoff;

  function automatic state_e first_step(input kppr_item_t it);
    state_e s;
    if (it.glb1)      s = S_GDIV;
    else if (it.zero) s = S_ZERO;
    else if (it.keep) s = S_BYTE;
    else if (it.fin)  s = S_EDIV;
    else              s = S_IDLE;
    return s;
  endfunction

  function automatic state_e after_zero(input kppr_item_t it);
    state_e s;
    if (it.keep)     s = S_BYTE;
    else if (it.fin) s = S_EDIV;
    else             s = S_IDLE;
    return s;
  endfunction

  assign pop_o           = (state_q == S_IDLE) && q_valid_i;
  assign emit_free       = !out_valid_q || out_ready_i;
  // a result beat leaves the sequencer this cycle
  assign emit_now        = emit_free && (state_q == S_ZERO || state_q == S_BYTE ||
                                         state_q == S_END1 || state_q == S_END2);
  assign out_valid_o     = out_valid_q;
  assign write_address_o = out_addr_q;
  assign write_data_o    = out_data_q;
  assign run_last_o      = run_last_q;

  // d = (addr - lower + 4) / 2, quotient by 7 via reciprocal multiply
  always_comb begin
    div_addr = (state_q == S_EDIV) ? end_q : next_addr_q;
    diff     = div_addr - last_glb_q + LINK_BIAS;
    dval     = diff[ADDR_W-1:1];
    prod     = 39'(dval) * 39'(DIV7_RECIP);
    // remainder d - 7q, and -7 == 1 modulo 8
    rem      = dlo_q + quo_q[2:0];
    byt      = lz_q ? 4'd0 : {rem, quo_q[8]};
    regoff   = lz_q ? '0 : quo_q[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      start_q     <= '0;
      end_q       <= '0;
      prior_q     <= '0;
      next_addr_q <= '0;
      last_glb_q  <= '0;
      held_q      <= '0;
      quo_q       <= '0;
      dlo_q       <= '0;
      lz_q        <= 1'b0;
      out_valid_q <= 1'b0;
      run_last_q  <= 1'b0;
      out_addr_q  <= '0;
      out_data_q  <= '0;
    end else begin
      out_valid_q <= emit_now || (out_valid_q && !out_ready_i);
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            cur_q   <= q_item_i;
            state_q <= first_step(q_item_i);
          end
        end
        S_GDIV: begin
          quo_q      <= prod[DIV7_SHIFT +: 9];
          dlo_q      <= dval[2:0];
          lz_q       <= (last_glb_q == '0);
          last_glb_q <= next_addr_q;
          state_q    <= cur_q.zero ? S_ZERO : S_BYTE;
        end
        S_EDIV: begin
          quo_q   <= prod[DIV7_SHIFT +: 9];
          dlo_q   <= dval[2:0];
          lz_q    <= (last_glb_q == '0);
          state_q <= S_END1;
        end
        S_ZERO: begin
          if (emit_free) begin
            out_addr_q  <= next_addr_q;
            out_data_q  <= '0;
            run_last_q  <= !cur_q.keep && !cur_q.fin;
            next_addr_q <= next_addr_q + ADDR_STEP;
            state_q     <= after_zero(cur_q);
          end
        end
        S_BYTE: begin
          if (emit_free) begin
            out_addr_q  <= next_addr_q;
            if (cur_q.glb1) begin
              out_data_q <= GLOBAL_TAG | {4'd0, byt};
              held_q     <= regoff;
            end else if (cur_q.glb2) begin
              out_data_q <= held_q;
            end else begin
              out_data_q <= cur_q.data;
            end
            run_last_q  <= !cur_q.fin;
            next_addr_q <= next_addr_q + ADDR_STEP;
            state_q     <= cur_q.fin ? S_EDIV : S_IDLE;
          end
        end
        S_END1: begin
          if (emit_free) begin
            out_addr_q  <= end_q;
            out_data_q  <= GLOBAL_TAG | {4'd0, byt};
            run_last_q  <= 1'b0;
            state_q     <= S_END2;
          end
        end
        S_END2: begin
          if (emit_free) begin
            out_addr_q  <= end_q + ADDR_STEP;
            out_data_q  <= regoff;
            run_last_q  <= 1'b1;
            // rearm for the next program
            next_addr_q <= start_q;
            last_glb_q  <= prior_q;
            held_q      <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_we_i) begin
        unique case (kppr_reg_e'(cfg_index_i))
          REG_START: begin
            start_q     <= cfg_data_i;
            next_addr_q <= cfg_data_i;
          end
          REG_END: end_q <= cfg_data_i;
          REG_PRIOR: begin
            prior_q    <= cfg_data_i;
            last_glb_q <= cfg_data_i;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_ediv_on_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EDIV) |-> cur_q.fin)
    else $error("relink of end header without final beat");
  a_gdiv_on_glb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GDIV) |-> (cur_q.glb1 && cur_q.keep))
    else $error("link offset run for a non-global byte");
  a_end_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_END1 && emit_free) |=> (state_q == S_END2 && out_valid_q && !run_last_q))
    else $error("end header beats out of order");
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_END2 && emit_free) |=> (next_addr_q == start_q && held_q == '0))
    else $error("addresses not rearmed after final beat");
`endif

endmodule
`default_nettype wire

/* rtl/keystroke_program_pack_relink_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keystroke_program_pack_relink_unit
// Packs keystroke program bytes, chains global headers and relinks the final
// end header, writing each surviving byte with its nibble address.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid_i / in_ready_o   code_byte_i, final_byte_i
//  out      out_valid_o / out_ready_i write_address_o, write_data_o, run_last_o
//  cfg      cfg_we_i                  cfg_index_i, cfg_data_i
//
//  The decoder takes one byte a cycle into a two-entry queue while the queue
//  has room. The sequencer pops an item only when idle, then emits one result
//  beat per state, with a divide state before each link offset (global header
//  or final relink); it takes no new item until it is through with the last.
//  Reset: decoder in its first state, all address registers zero, no result.
//  A stalled output holds the sequencer; the queue keeps the input open for
//  two more beats.
// ----------------------------------------------------------------------------
module keystroke_program_pack_relink_unit (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  [kppr_pkg::BYTE_W-1:0] code_byte_i,
  input  wire                         final_byte_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [kppr_pkg::ADDR_W-1:0] write_address_o,
  output logic [kppr_pkg::BYTE_W-1:0] write_data_o,
  output logic                        run_last_o,
  input  wire                         cfg_we_i,
  input  wire  [1:0]                  cfg_index_i,
  input  wire  [kppr_pkg::ADDR_W-1:0] cfg_data_i
);
  import kppr_pkg::*;

  kppr_item_t push_item, pop_item;
  logic       push, q_ready, q_valid, pop;

  kppr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .code_byte_i (code_byte_i),
    .final_byte_i(final_byte_i),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .item_o      (push_item)
  );

  kppr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .ready_o(q_ready),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (pop_item)
  );

  kppr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .q_valid_i      (q_valid),
    .q_item_i       (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_address_o(write_address_o),
    .write_data_o   (write_data_o),
    .run_last_o     (run_last_o)
  );

endmodule
`default_nettype wire

/* test/keystroke_program_pack_relink_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keystroke_program_pack_relink_unit_tb
// Feeds keystroke program bytes through the pack and relink unit under random
// idling on both channels and a long output stall. Every beat is checked
// against a local model of the length decoder, the global chaining and the
// end header relink.
// ----------------------------------------------------------------------------
module keystroke_program_pack_relink_unit_tb;
  import kppr_pkg::*;

  localparam int unsigned CLK_PERIOD_NS    = 12;
  localparam int unsigned RUN_LIMIT_CYCLES = 300000;
  localparam int unsigned SETTLE_CYCLES    = 24;
  localparam int unsigned CHOKE_CYCLES     = 400;
  localparam int unsigned PHASE_BYTES      = 28;
  localparam int unsigned NUM_PHASES       = 10;
  localparam logic [1:0]  REG_SPARE        = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              last;
  } nib_write_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              fin;
  } prog_byte_t;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [BYTE_W-1:0]   code_byte_i  = '0;
  logic                final_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [ADDR_W-1:0]   write_address_o;
  logic [BYTE_W-1:0]   write_data_o;
  logic                run_last_o;
  logic                cfg_we_i     = 1'b0;
  logic [1:0]          cfg_index_i  = '0;
  logic [ADDR_W-1:0]   cfg_data_i   = '0;

  keystroke_program_pack_relink_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .code_byte_i    (code_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_address_o(write_address_o),
    .write_data_o   (write_data_o),
    .run_last_o     (run_last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  prog_byte_t  byte_backlog[$];
  nib_write_t  pending_writes[$];
  int unsigned fault_count = 0;

  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  bit          choke_go  = 1'b0;
  logic        choke_on  = 1'b0;
  logic [3:0]  send_gap  = '0;
  logic [3:0]  recv_gap  = '0;

  // local copy of the register file and decoder state
  logic [ADDR_W-1:0] mirror_start = '0;
  logic [ADDR_W-1:0] mirror_end   = '0;
  logic [ADDR_W-1:0] mirror_prior = '0;
  kppr_kind_e        prev_kind    = K_FIRST;
  logic [3:0]        txt_left     = '0;
  logic              in_num       = 1'b0;
  logic [ADDR_W-1:0] next_addr    = '0;
  logic [ADDR_W-1:0] last_glb     = '0;
  logic [BYTE_W-1:0] held_reg     = '0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD_NS / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  function automatic void rearm_model();
    prev_kind = K_FIRST;
    txt_left  = '0;
    in_num    = 1'b0;
    next_addr = mirror_start;
    last_glb  = mirror_prior;
    held_reg  = '0;
  endfunction

  function automatic void mirror_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] val);
    case (idx)
      REG_START: begin
        mirror_start = val;
        next_addr    = val;
      end
      REG_END: mirror_end = val;
      REG_PRIOR: begin
        mirror_prior = val;
        last_glb     = val;
      end
      default: ;
    endcase
  endfunction

  function automatic kppr_kind_e opening_kind(input logic [BYTE_W-1:0] b);
    kppr_kind_e k;
    if ((b >= 8'h90 && b <= 8'hB0) || b == 8'hCE || b == 8'hCF) begin
      k = K_DBL1;
    end else if (b >= 8'hB1 && b <= 8'hBF) begin
      k = K_LOC1;
    end else if (b >= 8'hD0 && b <= 8'hEF) begin
      k = K_TRI1;
    end else if (b >= 8'hF0) begin
      txt_left = b[3:0];
      k = K_TEXT;
    end else if (b >= 8'h1D && b <= 8'h1F) begin
      k = K_JTEXT;
    end else if (b >= 8'hC0 && b <= 8'hCD) begin
      k = K_GLB1;
    end else begin
      k = K_SINGLE;
    end
    return k;
  endfunction

  function automatic kppr_kind_e kind_after(input kppr_kind_e prev, input logic [BYTE_W-1:0] b);
    kppr_kind_e k;
    case (prev)
      K_LOC1: k = K_LOC2;
      K_DBL1: k = K_DBL2;
      K_TRI1: k = K_TRI2;
      K_TRI2: k = K_TRI3;
      K_GLB1: k = K_GLB2;
      K_TEXT, K_GKEY: begin
        if (txt_left != 0) begin
          txt_left = txt_left - 4'd1;
          k = K_TEXT;
        end else begin
          k = opening_kind(b);
        end
      end
      K_JTEXT: begin
        if (b > 8'hF0) begin
          txt_left = b[3:0];
          k = K_TEXT;
        end else begin
          k = opening_kind(b);
        end
      end
      K_GLB2: begin
        if (b >= 8'hF0) begin
          txt_left = b[3:0];
          k = K_GLBL;
        end else begin
          k = K_GEND;
        end
      end
      K_GLBL: begin
        if (txt_left != 0) begin
          txt_left = txt_left - 4'd1;
          k = K_GKEY;
        end else begin
          k = opening_kind(b);
        end
      end
      default: k = opening_kind(b);
    endcase
    return k;
  endfunction

  // {register offset, byte offset} of a header at here chained to lower
  function automatic logic [15:0] chain_offsets(input logic [ADDR_W-1:0] here,
                                                input logic [ADDR_W-1:0] lower);
    logic [ADDR_W-1:0] span;
    logic [18:0]       halves;
    logic [18:0]       quot;
    logic [18:0]       rem;
    if (lower == '0) begin
      return 16'h0000;
    end
    span   = here - lower + LINK_BIAS;
    halves = span[ADDR_W-1:1];
    quot   = halves / 19'd7;
    rem    = halves % 19'd7;
    return {quot[7:0], 4'b0000, rem[2:0], quot[8]};
  endfunction

  function automatic void push_write(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
    nib_write_t w;
    w.addr = addr;
    w.data = data;
    w.last = 1'b0;
    pending_writes.push_back(w);
  endfunction

  function automatic void predict_writes(input logic [BYTE_W-1:0] raw, input logic fin);
    kppr_kind_e  k;
    logic [BYTE_W-1:0] b;
    logic [15:0] offs;
    logic        num;
    int unsigned first;
    nib_write_t  w;
    first = pending_writes.size();
    b = raw;
    k = kind_after(prev_kind, raw);
    case (k)
      K_GLB1: begin
        offs     = chain_offsets(next_addr, last_glb);
        last_glb = next_addr;
        held_reg = offs[15:8];
        b        = GLOBAL_TAG | offs[7:0];
      end
      K_GLB2: b = held_reg;
      K_GEND: b = END_CODE;
      K_GKEY, K_LOC2, K_TRI2: b = '0;
      K_TRI1: b = raw & TRI1_MASK;
      K_TRI3: b = raw & TRI3_MASK;
      default: ;
    endcase
    prev_kind = k;

    num = (k == K_SINGLE) && b >= NUM_LO && b <= NUM_HI;
    if (in_num && !num) begin
      push_write(next_addr, 8'h00);
      next_addr = next_addr + ADDR_STEP;
    end
    in_num = num;

    // plain NULL bytes vanish
    if (k != K_SINGLE || b != 8'h00) begin
      push_write(next_addr, b);
      next_addr = next_addr + ADDR_STEP;
    end

    if (fin) begin
      offs = chain_offsets(mirror_end, last_glb);
      push_write(mirror_end, GLOBAL_TAG | offs[7:0]);
      push_write(mirror_end + ADDR_STEP, offs[15:8]);
      rearm_model();
    end

    if (pending_writes.size() > first) begin
      w = pending_writes.pop_back();
      w.last = 1'b1;
      pending_writes.push_back(w);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [BYTE_W-1:0] pick(input int unsigned lo, input int unsigned hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic [3:0] idle_draw(input bit enabled);
    if (!enabled || $urandom_range(0, 1) == 0) begin
      return 4'd0;
    end
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic void queue_byte(input logic [BYTE_W-1:0] code, input logic fin);
    prog_byte_t t;
    t.code = code;
    t.fin  = fin;
    byte_backlog.push_back(t);
  endfunction

  function automatic void queue_text(ref logic [BYTE_W-1:0] ins[$]);
    logic [BYTE_W-1:0] lead;
    lead = pick(8'hF0, 8'hFF);
    ins.push_back(lead);
    repeat (lead[3:0]) ins.push_back(pick(0, 255));
  endfunction

  function automatic void queue_instruction();
    logic [BYTE_W-1:0] ins[$];
    logic [BYTE_W-1:0] lead;
    int unsigned       n;
    case ($urandom_range(0, 11))
      0, 1: repeat ($urandom_range(1, 5)) ins.push_back(pick(8'h10, 8'h1C));
      2: begin
        lead = pick(0, 8'h8F);
        if (lead >= 8'h10 && lead <= 8'h1F) begin
          lead = lead & 8'h0F;
        end
        ins.push_back(lead);
      end
      3: ins.push_back(8'h00);
      4: begin
        ins.push_back(($urandom_range(0, 7) == 0) ? pick(8'hCE, 8'hCF) : pick(8'h90, 8'hB0));
        ins.push_back(pick(0, 255));
      end
      5: begin
        ins.push_back(pick(8'hB1, 8'hBF));
        ins.push_back(pick(0, 255));
      end
      6: begin
        ins.push_back(pick(8'hD0, 8'hEF));
        repeat (2) ins.push_back(pick(0, 255));
      end
      7: queue_text(ins);
      8: begin
        ins.push_back(pick(8'h1D, 8'h1F));
        if ($urandom_range(0, 3) != 0) begin
          queue_text(ins);
        end
      end
      9, 10: begin
        ins.push_back(pick(8'hC0, 8'hCD));
        ins.push_back(pick(0, 255));
        if ($urandom_range(0, 1) == 0) begin
          queue_text(ins);
        end else begin
          ins.push_back(pick(0, 8'hEF));
        end
      end
      default: ins.push_back(pick(0, 255));
    endcase
    // cut an instruction short now and then
    n = ins.size();
    if (n > 1 && $urandom_range(0, 11) == 0) begin
      n = $urandom_range(1, n - 1);
    end
    for (int unsigned j = 0; j < n; j++) begin
      queue_byte(ins[j], 1'b0);
    end
  endfunction

  function automatic void queue_program();
    prog_byte_t t;
    repeat ($urandom_range(1, 10)) queue_instruction();
    if ($urandom_range(0, 7) != 0) begin
      t = byte_backlog.pop_back();
      t.fin = 1'b1;
      byte_backlog.push_back(t);
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mirror_reg(idx, val);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (byte_backlog.size() != 0 || in_valid_i || pending_writes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void log_fault(input string what, input nib_write_t want,
                                    input nib_write_t seen);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s: expected addr=%05h data=%02h last=%0b, got addr=%05h data=%02h last=%0b",
               what, want.addr, want.data, want.last, seen.addr, seen.data, seen.last);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : byte_feed
    prog_byte_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_writes(code_byte_i, final_byte_i);
      end
      // an offered beat stays put until taken
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 4'd1;
        end else if (byte_backlog.size() != 0) begin
          nxt = byte_backlog.pop_front();
          in_valid_i   <= 1'b1;
          code_byte_i  <= nxt.code;
          final_byte_i <= nxt.fin;
          send_gap     <= idle_draw(send_idle);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : write_check
    nib_write_t seen;
    nib_write_t want;
    logic [3:0] gap_n;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap    <= '0;
    end else begin
      gap_n = (recv_gap != 0) ? recv_gap - 4'd1 : 4'd0;
      if (out_valid_o && out_ready_i) begin
        seen = {write_address_o, write_data_o, run_last_o};
        if (pending_writes.size() == 0) begin
          log_fault("unexpected beat", '0, seen);
        end else begin
          want = pending_writes.pop_front();
          if (seen !== want) begin
            log_fault("beat mismatch", want, seen);
          end
        end
        gap_n = idle_draw(recv_idle);
      end
      recv_gap    <= gap_n;
      out_ready_i <= !choke_on && gap_n == 0;
    end
  end

  // long output stall so the unit backs up into its input
  initial begin : recv_choke
    wait (choke_go);
    @(posedge clk_i);
    choke_on <= 1'b1;
    repeat (CHOKE_CYCLES) @(posedge clk_i);
    choke_on <= 1'b0;
  end

  initial begin : run_guard
    #(RUN_LIMIT_CYCLES * CLK_PERIOD_NS);
    $display("FAIL keystroke_program_pack_relink_unit");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run_plan
    logic [BYTE_W-1:0] opening_bytes[$];
    logic [ADDR_W-1:0] s_addr;
    logic [ADDR_W-1:0] e_addr;
    logic [ADDR_W-1:0] p_addr;
    // NULL first, number run closed by a NULL, every instruction shape,
    // jump text into a zero-length string, number run left open at the end
    opening_bytes = '{8'h00, 8'h10, 8'h1C, 8'h00, 8'h90, 8'hFF, 8'hB1, 8'h55,
                      8'hEF, 8'hFF, 8'hFF, 8'hC0, 8'h12, 8'h34, 8'hCD, 8'h00,
                      8'hF2, 8'h41, 8'h42, 8'h1D, 8'hF1, 8'h7F, 8'h1F, 8'hF0,
                      8'hCE, 8'h00, 8'h11, 8'h12};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // start close to the top so the address wraps mid-program
    write_reg(REG_START, 20'hFFFF8);
    write_reg(REG_END, 20'hFFFFF);
    write_reg(REG_PRIOR, 20'h00000);
    write_reg(REG_SPARE, 20'hABCDE);
    foreach (opening_bytes[i]) begin
      queue_byte(opening_bytes[i], i == opening_bytes.size() - 1);
    end
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          s_addr = '0;
          e_addr = '0;
          p_addr = '0;
        end
        1: begin
          s_addr = 20'hFFFFF;
          e_addr = 20'hFFFFF;
          p_addr = 20'hFFFFF;
        end
        2: begin
          s_addr = 20'h00001;
          e_addr = 20'h80000;
          p_addr = 20'h00002;
        end
        3: begin
          s_addr = 20'hFFFF0;
          e_addr = 20'($urandom);
          p_addr = 20'h00001;
        end
        default: begin
          s_addr = 20'($urandom);
          e_addr = 20'($urandom);
          p_addr = ($urandom_range(0, 3) == 0) ? 20'h00000 : 20'($urandom);
        end
      endcase
      send_idle = (ph != 2 && ph != 4);
      recv_idle = (ph != 2);
      write_reg(REG_PRIOR, p_addr);
      write_reg(REG_START, s_addr);
      write_reg(REG_END, e_addr);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_SPARE, 20'($urandom));
      end
      if (ph == 4) begin
        choke_go = 1'b1;
      end
      while (byte_backlog.size() < PHASE_BYTES) begin
        queue_program();
      end
      wait_idle();
    end

    if (fault_count == 0 && pending_writes.size() == 0) begin
      $display("PASS keystroke_program_pack_relink_unit");
    end else begin
      $display("FAIL keystroke_program_pack_relink_unit");
    end
    $finish;
  end

endmodule
